### rtl/core/multicore_task_scheduler_macros.svh
// assertion macros for the multicore task scheduler
`ifndef MULTICORE_TASK_SCHEDULER_MACROS_SVH
`define MULTICORE_TASK_SCHEDULER_MACROS_SVH
`define MTS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("lbl");
`define MTS_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("lbl");
`endif

### rtl/core/mts_pkg.sv
// package for the multicore task scheduler: types and constants
package mts_pkg;
  localparam int TASKS = 8;
  localparam int CORES = 3;
  localparam int SEMS = 8;
  localparam int TW = $clog2(TASKS);
  localparam int IDLE_BASE = (TASKS > CORES) ? TASKS - CORES : 0;
  localparam logic [31:0] SLICE_RESET = 32'h1111_3142;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_IPI = 3'd1;
  localparam logic [2:0] OP_YIELD = 3'd2;
  localparam logic [2:0] OP_ACQ = 3'd3;
  localparam logic [2:0] OP_TRY = 3'd4;
  localparam logic [2:0] OP_REL = 3'd5;
  localparam logic [2:0] OP_SNOOZE = 3'd6;

  typedef struct packed {
    logic [2:0] opcode;
    logic [1:0] core;
    logic [2:0] sem_id;
    logic [15:0] snooze_ticks;
  } in_word_t;

  typedef struct packed {
    logic [2:0] next_task;
    logic switched;
    logic granted;
    logic [2:0] ipi_mask;
  } out_word_t;

  typedef struct packed {
    logic go;
    logic [1:0] core;
    logic [TW-1:0] cur;
  } pick_req_t;

  typedef struct packed {
    logic done;
    logic [TW-1:0] task_id;
  } pick_rsp_t;

  function automatic logic [3:0] slice_of(logic [31:0] tbl, logic [TW-1:0] t);
    logic [3:0] r;
    r = 4'd1;
    for (int i = 0; i < 8; i++) begin
      if (i < TASKS && int'(t) == i) r = tbl[4*i +: 4];
    end
    return r;
  endfunction

  function automatic logic [TW-1:0] idle_of(logic [1:0] c);
    return TW'((IDLE_BASE + int'(c)) % TASKS);
  endfunction
endpackage

### rtl/core/mts_picker.sv
// round-robin next-task search, one candidate per cycle
module mts_picker (
  input  logic clk,
  input  logic rst_n,
  input  mts_pkg::pick_req_t req,
  input  logic [mts_pkg::TASKS-1:0] ready,
  input  logic [mts_pkg::TASKS-1:0] owned,
  output mts_pkg::pick_rsp_t rsp
);
  import mts_pkg::*;
  logic busy_r;
  logic [TW-1:0] t_r, cur_r;
  logic [1:0] core_r;
  logic [TW-1:0] nt;
  logic stop;

  always_comb begin
    nt = (int'(t_r) == TASKS - 1) ? '0 : t_r + 1'b1;
    stop = (ready[nt] && !(owned[nt] && nt != cur_r) && int'(nt) < IDLE_BASE)
           || nt == cur_r;
  end

  always_ff @(posedge clk) begin
    rsp.done <= 1'b0;
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.go) begin
      busy_r <= 1'b1;
      t_r <= req.cur;
      cur_r <= req.cur;
      core_r <= req.core;
    end else if (busy_r) begin
      t_r <= nt;
      if (stop) begin
        busy_r <= 1'b0;
        rsp.done <= 1'b1;
        rsp.task_id <= ready[nt] ? nt : idle_of(core_r);
      end
    end
  end
endmodule

### rtl/core/multicore_task_scheduler.sv
// top level of the multicore task scheduler
// Hardware round-robin scheduler for CORES cores, TASKS tasks, SEMS semaphores.
// Input channel: in_word is taken at a clock edge where start is high and
// busy is low. Each event gives exactly one result word on out_word, shown for
// one cycle with out_valid; the receiver cannot stall, so no result waits.
// Config channel: cfg_valid/cfg_ready writes the slice table and reloads every
// task's slice counter; cfg_ready is high while the block is idle.
// Sequencing: an event without reschedule passes S_EXEC, S_PICK and S_WAIT, and
// its result shows in the cycle after; a tick on core 0 or a release first walks
// the task table one task per cycle, and a reschedule then launches the shared
// picker, which walks the ring again before the result is registered.
// The next word can be taken in the cycle that shows the result.
// Reset (rst_n low, synchronous) puts each core on its idle task, all tasks
// ready, all semaphores free and the slice table to its default.
module multicore_task_scheduler (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  mts_pkg::in_word_t in_word,
  output logic out_valid,
  output mts_pkg::out_word_t out_word,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [31:0] cfg_data
);
  import mts_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_SCAN, S_PICK, S_WAIT} state_t;
  state_t state_r;
  in_word_t iw_r;
  logic [31:0] slice_r;
  logic [TW-1:0] cur_core_r [CORES];
  logic [TASKS-1:0] ready_r, owned_r, waitv_r;
  logic [3:0] sl_r [TASKS];
  logic [15:0] sleep_r [TASKS];
  logic [2:0] wsem_r [TASKS];
  logic [SEMS-1:0] semb_r;
  logic [TW-1:0] semh_r [SEMS];
  logic [TW-1:0] cur_r, scan_r;
  logic gr_r, rs_r;
  logic [2:0] ipi_r;
  pick_req_t preq;
  pick_rsp_t prsp;
  logic [2:0] om;
  logic sem_ok;
  logic [TW-1:0] s_idx;
  logic u_busy_guard;

  mts_picker u_pick (.clk, .rst_n, .req(preq), .ready(ready_r), .owned(owned_r),
    .rsp(prsp));

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign om = 3'(((1 << CORES) - 1) & ~(1 << iw_r.core));
  assign sem_ok = int'(iw_r.sem_id) < SEMS;
  assign s_idx = TW'(iw_r.sem_id);

  always_ff @(posedge clk) begin
    preq.go <= 1'b0;
    out_valid <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      slice_r <= SLICE_RESET;
      ready_r <= '1;
      waitv_r <= '0;
      semb_r <= '0;
      owned_r <= '0;
      for (int i = 0; i < TASKS; i++) begin
        sl_r[i] <= slice_of(SLICE_RESET, TW'(i));
        sleep_r[i] <= '0;
      end
      for (int c = 0; c < CORES; c++) begin
        cur_core_r[c] <= idle_of(2'(c));
        owned_r[idle_of(2'(c))] <= 1'b1;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            slice_r <= cfg_data;
            for (int i = 0; i < TASKS; i++) sl_r[i] <= slice_of(cfg_data, TW'(i));
          end
          if (start) begin
            iw_r <= in_word;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          gr_r <= 1'b0;
          rs_r <= 1'b0;
          ipi_r <= '0;
          scan_r <= '0;
          if (int'(iw_r.core) >= CORES) begin
            out_word <= '0;
            out_valid <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            cur_r <= cur_core_r[iw_r.core];
            state_r <= S_PICK;
            unique case (iw_r.opcode)
              OP_TICK: if (iw_r.core == 2'd0) state_r <= S_SCAN;
              OP_REL: if (sem_ok) begin
                semb_r[s_idx] <= 1'b0;
                state_r <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          scan_r <= scan_r + 1'b1;
          if (iw_r.opcode == OP_TICK) begin
            if (!ready_r[scan_r] && sleep_r[scan_r] != '0) begin
              sleep_r[scan_r] <= sleep_r[scan_r] - 1'b1;
              if (sleep_r[scan_r] == 16'd1) begin
                ready_r[scan_r] <= 1'b1;
                ipi_r <= om;
              end
            end
          end else if (!ready_r[scan_r] && waitv_r[scan_r] && wsem_r[scan_r] == iw_r.sem_id) begin
            waitv_r[scan_r] <= 1'b0;
            sleep_r[scan_r] <= '0;
            ready_r[scan_r] <= 1'b1;
            ipi_r <= om;
            rs_r <= 1'b1;
          end
          if (int'(scan_r) == TASKS - 1) state_r <= S_PICK;
        end
        S_PICK: begin
          state_r <= S_WAIT;
          unique case (iw_r.opcode)
            OP_TICK: begin
              if (sl_r[cur_r] <= 4'd1) begin
                sl_r[cur_r] <= slice_of(slice_r, cur_r);
                rs_r <= 1'b1;
              end else sl_r[cur_r] <= sl_r[cur_r] - 1'b1;
            end
            OP_IPI: rs_r <= int'(cur_r) >= IDLE_BASE;
            OP_YIELD: rs_r <= 1'b1;
            OP_ACQ: if (sem_ok) begin
              if (!semb_r[s_idx]) begin
                semb_r[s_idx] <= 1'b1;
                semh_r[s_idx] <= cur_r;
                gr_r <= 1'b1;
              end else begin
                waitv_r[cur_r] <= 1'b1;
                wsem_r[cur_r] <= iw_r.sem_id;
                ready_r[cur_r] <= 1'b0;
                rs_r <= 1'b1;
              end
            end
            OP_TRY: if (sem_ok) begin
              if (!semb_r[s_idx]) begin
                semb_r[s_idx] <= 1'b1;
                semh_r[s_idx] <= cur_r;
                gr_r <= 1'b1;
              end else gr_r <= semh_r[s_idx] == cur_r;
            end
            OP_SNOOZE: begin
              sleep_r[cur_r] <= iw_r.snooze_ticks;
              ready_r[cur_r] <= 1'b0;
              rs_r <= 1'b1;
            end
            default: ;
          endcase
        end
        S_WAIT: begin
          if (!rs_r) begin
            out_word <= '{next_task: 3'(cur_r), switched: 1'b0, granted: gr_r,
                          ipi_mask: ipi_r};
            out_valid <= 1'b1;
            state_r <= S_IDLE;
          end else if (!preq.go && !prsp.done && !owned_r[cur_r] == 1'b0) begin
            owned_r[cur_r] <= 1'b0;
            preq <= '{go: 1'b1, core: iw_r.core, cur: cur_r};
          end else if (prsp.done) begin
            owned_r[prsp.task_id] <= 1'b1;
            cur_core_r[iw_r.core] <= prsp.task_id;
            out_word <= '{next_task: 3'(prsp.task_id), switched: prsp.task_id != cur_r,
                          granted: gr_r, ipi_mask: ipi_r};
            out_valid <= 1'b1;
            state_r <= S_IDLE;
          end else if (!preq.go && owned_r[cur_r] == 1'b0 && !u_busy_guard) begin
            preq <= '{go: 1'b1, core: iw_r.core, cur: cur_r};
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // picker launched once: guard tracks an outstanding search
  always_ff @(posedge clk) begin
    if (!rst_n || state_r != S_WAIT) u_busy_guard <= 1'b0;
    else if (preq.go) u_busy_guard <= 1'b1;
  end
endmodule

### rtl/core/mts_checker.sv
// port-level checker for the multicore task scheduler
`include "multicore_task_scheduler_macros.svh"
module mts_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_ready
);
  `MTS_ASSERT(a_take_busy, clk, rst_n, (start && !busy) |=> busy)
  `MTS_ASSERT(a_out_ends, clk, rst_n, out_valid |-> !busy)
  `MTS_ASSERT(a_cfg_idle, clk, rst_n, cfg_ready == !busy)
  `MTS_ASSERT(a_one_out, clk, rst_n, out_valid |=> !out_valid)
  `MTS_ASSERT_NR(a_reset, clk, !rst_n |=> !busy && !out_valid)
endmodule

bind multicore_task_scheduler mts_checker u_mts_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .cfg_ready
);

### verif/testbench.sv
// self-checking testbench for the multicore task scheduler
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mts_pkg::*;

  localparam logic [2:0] OP_UNDEF = 3'd7;
  localparam int IDLE_LIMIT = 5000;

  class sched_scoreboard;
    bit [31:0] slices;
    bit [2:0] on_core[CORES];
    bit rdy[TASKS];
    bit owned[TASKS];
    bit [1:0] owner[TASKS];
    bit [3:0] slice_left[TASKS];
    bit [15:0] sleep_left[TASKS];
    bit waiting[TASKS];
    bit [2:0] wait_sem[TASKS];
    bit held[SEMS];
    bit [2:0] holder[SEMS];
    out_word_t pending[$];
    int errors;

    function new();
      slices = SLICE_RESET;
      errors = 0;
      for (int t = 0; t < TASKS; t++) begin
        rdy[t] = 1;
        owned[t] = 0;
        owner[t] = 0;
        slice_left[t] = slice_for(t);
        sleep_left[t] = 0;
        waiting[t] = 0;
        wait_sem[t] = 0;
      end
      for (int s = 0; s < SEMS; s++) begin
        held[s] = 0;
        holder[s] = 0;
      end
      for (int c = 0; c < CORES; c++) begin
        on_core[c] = 3'(idle_task(c));
        owned[idle_task(c)] = 1;
        owner[idle_task(c)] = 2'(c);
      end
    endfunction

    function bit [3:0] slice_for(int t);
      return (t < 8) ? slices[4*t +: 4] : 4'd1;
    endfunction

    function int idle_task(int c);
      return (IDLE_BASE + c) % TASKS;
    endfunction

    function void write_slices(bit [31:0] v);
      slices = v;
      for (int t = 0; t < TASKS; t++) slice_left[t] = slice_for(t);
    endfunction

    function int pick_task(int c);
      int cur;
      int t;
      cur = on_core[c];
      t = cur;
      owned[cur] = 0;
      do t = (t + 1) % TASKS;
      while ((!rdy[t] || owned[t] || t >= IDLE_BASE) && t != cur);
      if (!rdy[t]) t = idle_task(c);
      owned[t] = 1;
      owner[t] = 2'(c);
      return t;
    endfunction

    function void note_event(in_word_t w);
      out_word_t r;
      int c;
      int cur;
      int s;
      bit resched;
      bit [2:0] others;
      c = w.core;
      s = w.sem_id;
      r = '0;
      resched = 0;
      if (c >= CORES) begin
        pending.push_back(r);
        return;
      end
      cur = on_core[c];
      others = 3'(((1 << CORES) - 1) & ~(1 << c));
      case (w.opcode)
        OP_TICK: begin
          if (c == 0) begin
            for (int t = 0; t < TASKS; t++) begin
              if (!rdy[t] && sleep_left[t] > 0) begin
                sleep_left[t]--;
                if (sleep_left[t] == 0) begin
                  rdy[t] = 1;
                  r.ipi_mask = others;
                end
              end
            end
          end
          if (slice_left[cur] <= 1) begin
            slice_left[cur] = slice_for(cur);
            resched = 1;
          end else begin
            slice_left[cur]--;
          end
        end
        OP_IPI: resched = cur >= IDLE_BASE;
        OP_YIELD: resched = 1;
        OP_ACQ: begin
          if (!held[s]) begin
            held[s] = 1;
            holder[s] = 3'(cur);
            r.granted = 1;
          end else begin
            waiting[cur] = 1;
            wait_sem[cur] = 3'(s);
            rdy[cur] = 0;
            resched = 1;
          end
        end
        OP_TRY: begin
          if (!held[s]) begin
            held[s] = 1;
            holder[s] = 3'(cur);
          end
          r.granted = held[s] && holder[s] == cur;
        end
        OP_REL: begin
          held[s] = 0;
          for (int t = 0; t < TASKS; t++) begin
            if (!rdy[t] && waiting[t] && wait_sem[t] == s) begin
              waiting[t] = 0;
              sleep_left[t] = 0;
              rdy[t] = 1;
              r.ipi_mask = others;
              resched = 1;
            end
          end
        end
        OP_SNOOZE: begin
          sleep_left[cur] = w.snooze_ticks;
          rdy[cur] = 0;
          resched = 1;
        end
        default: ;
      endcase
      if (resched) on_core[c] = 3'(pick_task(c));
      r.next_task = on_core[c];
      r.switched = on_core[c] != cur;
      pending.push_back(r);
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        report("unexpected word", got, 8'd0);
        return;
      end
      want = pending.pop_front();
      if (got.next_task !== want.next_task) report("next_task", got.next_task, want.next_task);
      if (got.switched !== want.switched) report("switched", got.switched, want.switched);
      if (got.granted !== want.granted) report("granted", got.granted, want.granted);
      if (got.ipi_mask !== want.ipi_mask) report("ipi_mask", got.ipi_mask, want.ipi_mask);
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_word_t in_word;
  logic out_valid;
  out_word_t out_word;
  logic cfg_valid;
  logic cfg_ready;
  logic [31:0] cfg_data;

  sched_scoreboard sb = new();
  int burst_left;
  int quiet_cycles;

  multicore_task_scheduler i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_event(in_word);
      if (cfg_valid && cfg_ready) sb.write_slices(cfg_data);
      if (out_valid) sb.check_result(out_word);
      if ((start && !busy) || (cfg_valid && cfg_ready) || out_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task send_event(logic [2:0] op, logic [1:0] c, logic [2:0] s, logic [15:0] ticks);
    if (!start) start <= 1;
    in_word <= '{opcode: op, core: c, sem_id: s, snooze_ticks: ticks};
    do @(posedge clk); while (busy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task drain;
    if (start) begin
      start <= 0;
      @(posedge clk);
    end
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (2 * TASKS + 4) @(posedge clk);
  endtask

  task write_slices(logic [31:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task random_event;
    logic [2:0] op;
    logic [1:0] c;
    logic [2:0] s;
    logic [15:0] ticks;
    int pick;
    c = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, CORES - 1));
    s = $urandom_range(0, 3) == 0 ? 3'($urandom) : 3'($urandom_range(0, 2));
    ticks = 16'($urandom_range(1, 6));
    pick = $urandom_range(0, 99);
    if (pick < 30) op = OP_TICK;
    else if (pick < 38) op = OP_IPI;
    else if (pick < 48) op = OP_YIELD;
    else if (pick < 63) op = OP_ACQ;
    else if (pick < 71) op = OP_TRY;
    else if (pick < 86) op = OP_REL;
    else if (pick < 97) op = OP_SNOOZE;
    else op = OP_UNDEF;
    send_event(op, c, s, ticks);
  endtask

  initial begin
    logic [31:0] settings[4];
    rst_n = 0;
    start = 0;
    in_word = '0;
    cfg_valid = 0;
    cfg_data = '0;
    quiet_cycles = 0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset slice values first
    send_event(OP_TICK, 0, 0, 0);
    send_event(OP_IPI, 1, 0, 0);
    send_event(OP_YIELD, 2, 0, 0);
    send_event(OP_ACQ, 0, 7, 0);
    send_event(OP_ACQ, 1, 7, 0);
    send_event(OP_TRY, 0, 7, 0);
    send_event(OP_TRY, 2, 7, 0);
    send_event(OP_REL, 2, 7, 0);
    send_event(OP_SNOOZE, 1, 0, 16'd2);
    send_event(OP_TICK, 0, 0, 0);
    send_event(OP_TICK, 0, 0, 0);
    send_event(OP_UNDEF, 0, 0, 0);
    send_event(OP_TICK, 3, 7, 16'hffff);
    send_event(OP_REL, 1, 0, 0);

    write_slices(32'hffff_ffff);
    send_event(OP_TICK, 0, 0, 0);
    send_event(OP_TICK, 1, 0, 0);
    write_slices(32'h0000_0000);
    send_event(OP_TICK, 0, 0, 0);
    send_event(OP_TICK, 2, 0, 0);

    settings[0] = 32'h0000_0000;
    settings[1] = $urandom;
    settings[2] = 32'hffff_ffff;
    settings[3] = SLICE_RESET;
    for (int p = 0; p < 4; p++) begin
      write_slices(settings[p]);
      repeat (420) random_event();
    end

    // long and endless snoozes, idle tasks too, with no way back
    send_event(OP_SNOOZE, 0, 0, 16'hffff);
    send_event(OP_SNOOZE, 1, 0, 16'h0000);
    send_event(OP_SNOOZE, 2, 0, 16'h5a5a);
    send_event(OP_SNOOZE, 0, 0, 16'h0000);
    send_event(OP_IPI, 0, 0, 0);
    repeat (60) random_event();

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
